// ----- hdl/clsr_pkg.sv -----
// clsr_pkg: shared constants, op codes and unit handshake structs for the
// combined congruential shuffle generator. No dependencies.

package clsr_pkg;

    // field widths
    localparam int GEN_W      = 31;
    localparam int FRAC_W     = 24;
    localparam int PROD_W     = GEN_W + FRAC_W;

    // default shuffle table depth
    localparam int TABLE_SIZE = 32;

    // generator moduli and multipliers
    localparam logic [31:0] MOD_ONE  = 32'd2147483563;
    localparam logic [31:0] MOD_TWO  = 32'd2147483399;
    localparam logic [15:0] MUL_ONE  = 16'd40014;
    localparam logic [15:0] MUL_TWO  = 16'd40692;

    // 2^31 minus each modulus, used to fold the high part of a product
    localparam logic [7:0]  FOLD_ONE = 8'd85;
    localparam logic [7:0]  FOLD_TWO = 8'd249;

    // wrap added when the shuffled difference drops below one
    localparam logic [31:0] WRAP_ADD = 32'd2147483562;

    // largest fraction code, two steps below unity
    localparam logic [FRAC_W:0] FRAC_MAX = 25'd16777214;

    // reset values
    localparam logic [GEN_W-1:0] SEED_RESET = 31'd1;
    localparam logic [GEN_W-1:0] ONE_RESET  = 31'd1;
    localparam logic [GEN_W-1:0] TWO_RESET  = 31'd123456789;

    // operations of the modular multiply unit
    typedef enum logic [1:0] {
        MM_GEN_ONE = 2'd0,
        MM_GEN_TWO = 2'd1,
        MM_FRAC    = 2'd2
    } t_mm_op;

    typedef struct packed {
        logic             go;
        t_mm_op           op;
        logic [GEN_W-1:0] x;
    } t_mm_req;

    typedef struct packed {
        logic              done;
        t_mm_op            op;
        logic [GEN_W-1:0]  rem;
        logic [FRAC_W:0]   quo;
    } t_mm_rsp;

endpackage

// ----- hdl/clsr_if.sv -----
// clsr_if: valid/ready channel interfaces for requests, results and seed writes.
// Depends on clsr_pkg for field widths.

interface clsr_req_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface clsr_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [clsr_pkg::GEN_W-1:0]   sample;
    logic [clsr_pkg::FRAC_W-1:0]  fraction_q24;
    modport source (output valid, output sample, output fraction_q24, input ready);
    modport sink   (input valid, input sample, input fraction_q24, output ready);
endinterface

interface clsr_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [clsr_pkg::GEN_W-1:0] seed;
    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

// ----- hdl/combined_lcg_shuffle_rng.sv -----
// combined_lcg_shuffle_rng: two combined congruential generators with a
// shuffle table, run by a small sequencer over one shared multiply unit.
// Depends on clsr_pkg, clsr_if, clsr_ram and clsr_modmul.
//
// Usage: each request beat on i_req draws one sample; restart=1 first reloads
// both generators from the seed register and refills the shuffle table.
// Each request yields exactly one result beat on o_rsp carrying the 31-bit
// sample and its Q0.24 fraction. The seed is written on i_cfg, which is always
// ready, and should only be written while no draw is in flight.
// A plain draw issues two generator steps back to back on the shared modular
// multiply unit, then a table read, then the fraction step; a restart first
// runs the warm-up steps of generator one that refill the table. The slot
// quotient is worked out while the generator steps are under way.
// One request is in flight at a time: i_req.ready is high only while the
// sequencer is idle, so a new request is taken only once the last result
// has been loaded into the output register.
// Reset restores seed 1, generators 1 and 123456789, last output 0 and an
// all-zero table (per-entry valid bits, no clearing pass). When the receiver
// stalls, the result is held in the output register and the next result
// waits behind it.

module combined_lcg_shuffle_rng #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clsr_req_if.sink   i_req,
    clsr_rsp_if.source o_rsp,
    clsr_cfg_if.sink   i_cfg
);

    localparam int GW = clsr_pkg::GEN_W;
    localparam int FW = clsr_pkg::FRAC_W;
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int QW = AW + 1;
    localparam int RW = AW + QW + 1;
    localparam int EW = GW + RW;
    localparam int CW = $clog2(TABLE_SIZE + 8);
    localparam int NW = 2;
    localparam logic [31:0]   NDIV    = 32'd1 + (clsr_pkg::MOD_ONE - 32'd2) / TABLE_SIZE;
    // reciprocal of the slot width scaled by 2^(GW+QW), rounded down
    localparam logic [RW-1:0] RECIP   = RW'((64'd1 << (GW + QW)) / 64'(NDIV));

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_WARM_GO   = 10'b00_0000_0010,
        S_WARM_WAIT = 10'b00_0000_0100,
        S_DRAW_GO   = 10'b00_0000_1000,
        S_DRAW_TWO  = 10'b00_0001_0000,
        S_DRAW_WAIT = 10'b00_0010_0000,
        S_READ      = 10'b00_0100_0000,
        S_COMBINE   = 10'b00_1000_0000,
        S_FRAC_WAIT = 10'b01_0000_0000,
        S_EMIT      = 10'b10_0000_0000
    } t_state;

    t_state                r_state,      n_state;
    logic [GW-1:0]         r_seed,       n_seed;
    logic [GW-1:0]         r_fg,         n_fg;
    logic [GW-1:0]         r_sg,         n_sg;
    logic [GW-1:0]         r_last,       n_last;
    logic [CW-1:0]         r_cnt,        n_cnt;
    logic [TABLE_SIZE-1:0] r_valid,      n_valid;
    logic [GW-1:0]         r_div_rem,    n_div_rem;
    logic [QW-1:0]         r_div_q,      n_div_q;
    logic [NW-1:0]         r_div_n,      n_div_n;
    logic                  r_two_ok,     n_two_ok;
    logic [FW-1:0]         r_frac,       n_frac;
    logic                  r_out_vld,    n_out_vld;
    logic [GW-1:0]         r_out_sample, n_out_sample;
    logic [FW-1:0]         r_out_frac,   n_out_frac;

    clsr_pkg::t_mm_req mm_req;
    clsr_pkg::t_mm_rsp mm_rsp;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [GW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [GW-1:0] ram_rdata;

    logic          accept;
    logic [31:0]   seed_sub;
    logic [GW-1:0] seed_red;
    logic [GW-1:0] seed_x;
    logic [EW-1:0] est_prod;
    logic [QW-1:0] est_q;
    logic [31:0]   div_back;
    logic          div_ge;
    logic [AW-1:0] slot;
    logic [GW-1:0] tab_val;
    logic          tab_le;
    logic [31:0]   draw_sum;
    logic [FW-1:0] frac_clamp;

    // shared modular multiply unit
    clsr_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    // shuffle table storage
    clsr_ram #(
        .WIDTH (GW),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshakes
    assign i_req.ready  = (r_state == S_IDLE);
    assign accept       = i_req.valid && (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.sample       = r_out_sample;
    assign o_rsp.fraction_q24 = r_out_frac;

    // seed reduced once below the first modulus, zero mapped to one
    assign seed_sub = {1'b0, r_seed} - clsr_pkg::MOD_ONE;
    assign seed_red = ({1'b0, r_seed} >= clsr_pkg::MOD_ONE) ? seed_sub[GW-1:0] : r_seed;
    assign seed_x   = (seed_red == '0) ? GW'(1) : seed_red;

    // slot estimate by reciprocal multiply, low by at most one
    assign est_prod = EW'(r_last) * EW'(RECIP);
    assign est_q    = est_prod[EW-1:GW+QW];

    // one compare and subtract corrects the estimate
    assign div_back = 32'(r_div_q) * NDIV;
    assign div_ge   = ({1'b0, r_div_rem} >= NDIV);
    assign slot     = (r_div_q >= QW'(TABLE_SIZE)) ? AW'(TABLE_SIZE - 1) : r_div_q[AW-1:0];

    // shuffled difference with wrap, entries never written read as zero
    assign tab_val  = r_valid[slot] ? ram_rdata : '0;
    assign tab_le   = (tab_val <= r_sg);
    assign draw_sum = {1'b0, tab_val} - {1'b0, r_sg}
                    + (tab_le ? clsr_pkg::WRAP_ADD : 32'd0);

    // fraction clamped two steps below unity
    assign frac_clamp = (mm_rsp.quo > clsr_pkg::FRAC_MAX) ? clsr_pkg::FRAC_MAX[FW-1:0]
                                                          : mm_rsp.quo[FW-1:0];

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_seed       = r_seed;
        n_fg         = r_fg;
        n_sg         = r_sg;
        n_last       = r_last;
        n_cnt        = r_cnt;
        n_valid      = r_valid;
        n_div_rem    = r_div_rem;
        n_div_q      = r_div_q;
        n_div_n      = r_div_n;
        n_two_ok     = r_two_ok;
        n_frac       = r_frac;
        n_out_vld    = r_out_vld;
        n_out_sample = r_out_sample;
        n_out_frac   = r_out_frac;

        mm_req.go = 1'b0;
        mm_req.op = clsr_pkg::MM_GEN_ONE;
        mm_req.x  = r_fg;

        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = r_fg;
        ram_re    = 1'b0;
        ram_raddr = slot;

        // seed write beat
        if (i_cfg.valid) begin
            n_seed = i_cfg.seed;
        end

        // result beat taken
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        // slot quotient: remainder of the estimate, then the correcting step
        if (r_div_n == NW'(2)) begin
            n_div_rem = r_last - div_back[GW-1:0];
            n_div_n   = NW'(1);
        end else if (r_div_n == NW'(1)) begin
            n_div_q   = r_div_q + QW'(div_ge);
            n_div_n   = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.restart) begin
                        n_sg    = seed_x;
                        n_fg    = seed_x;
                        n_cnt   = CW'(TABLE_SIZE + 7);
                        n_state = S_WARM_GO;
                    end else begin
                        n_state = S_DRAW_GO;
                    end
                end
            end
            S_WARM_GO: begin
                mm_req.go = 1'b1;
                n_state   = S_WARM_WAIT;
            end
            S_WARM_WAIT: begin
                if (mm_rsp.done) begin
                    n_fg = mm_rsp.rem;
                    if (r_cnt < CW'(TABLE_SIZE)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_cnt[AW-1:0];
                        ram_wdata = mm_rsp.rem;
                        n_valid[r_cnt[AW-1:0]] = 1'b1;
                    end
                    if (r_cnt == '0) begin
                        n_last  = mm_rsp.rem;
                        n_state = S_DRAW_GO;
                    end else begin
                        n_cnt   = r_cnt - CW'(1);
                        n_state = S_WARM_GO;
                    end
                end
            end
            S_DRAW_GO: begin
                mm_req.go = 1'b1;
                n_div_q   = est_q;
                n_div_n   = NW'(2);
                n_two_ok  = 1'b0;
                n_state   = S_DRAW_TWO;
            end
            S_DRAW_TWO: begin
                mm_req.go = 1'b1;
                mm_req.op = clsr_pkg::MM_GEN_TWO;
                mm_req.x  = r_sg;
                n_state   = S_DRAW_WAIT;
            end
            S_DRAW_WAIT: begin
                if (mm_rsp.done) begin
                    if (mm_rsp.op == clsr_pkg::MM_GEN_TWO) begin
                        n_sg     = mm_rsp.rem;
                        n_two_ok = 1'b1;
                    end else begin
                        n_fg = mm_rsp.rem;
                    end
                end
                if (r_two_ok && (r_div_n == '0)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_COMBINE;
            end
            S_COMBINE: begin
                ram_we        = 1'b1;
                n_valid[slot] = 1'b1;
                n_last        = draw_sum[GW-1:0];
                mm_req.go     = 1'b1;
                mm_req.op     = clsr_pkg::MM_FRAC;
                mm_req.x      = draw_sum[GW-1:0];
                n_state       = S_FRAC_WAIT;
            end
            S_FRAC_WAIT: begin
                if (mm_rsp.done) begin
                    n_frac  = frac_clamp;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_sample = r_last;
                    n_out_frac   = r_frac;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seed    <= clsr_pkg::SEED_RESET;
            r_fg      <= clsr_pkg::ONE_RESET;
            r_sg      <= clsr_pkg::TWO_RESET;
            r_last    <= '0;
            r_valid   <= '0;
            r_div_n   <= '0;
            r_two_ok  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_seed    <= n_seed;
            r_fg      <= n_fg;
            r_sg      <= n_sg;
            r_last    <= n_last;
            r_valid   <= n_valid;
            r_div_n   <= n_div_n;
            r_two_ok  <= n_two_ok;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_div_rem    <= n_div_rem;
        r_div_q      <= n_div_q;
        r_frac       <= n_frac;
        r_out_sample <= n_out_sample;
        r_out_frac   <= n_out_frac;
    end

endmodule

// ----- hdl/clsr_ram.sv -----
// clsr_ram: generic single-write, single-read RAM with registered read data.
// Depends on clsr_pkg for default sizes.

module clsr_ram #(
    parameter int  WIDTH = clsr_pkg::GEN_W,
    parameter int  DEPTH = clsr_pkg::TABLE_SIZE,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/clsr_modmul.sv -----
// clsr_modmul: two-stage modular multiply / constant divide unit shared by
// both generators and the fraction step. Depends on clsr_pkg.

module clsr_modmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clsr_pkg::t_mm_req i_req,
    output clsr_pkg::t_mm_rsp o_rsp
);

    localparam int PW = clsr_pkg::PROD_W;
    localparam logic [32:0] MOD_ONE_X2 = {clsr_pkg::MOD_ONE, 1'b0};

    logic                        r_a_vld;
    clsr_pkg::t_mm_op            r_a_op;
    logic [PW-1:0]               r_a_val;
    logic                        r_b_vld;
    clsr_pkg::t_mm_op            r_b_op;
    logic [32:0]                 r_b_sum;
    logic [clsr_pkg::FRAC_W-1:0] r_b_hi;

    logic [15:0]                 mul_k;
    logic [46:0]                 prod;
    logic [PW-1:0]               n_a_val;
    logic [7:0]                  fold_k;
    logic [clsr_pkg::FRAC_W-1:0] a_hi;
    logic [32:0]                 n_b_sum;
    logic [31:0]                 mod_k;
    logic                        ge_one;
    logic                        ge_two;
    logic [32:0]                 sub_val;

    // stage a: raw product, or the sample shifted up for the fraction
    assign mul_k = (i_req.op == clsr_pkg::MM_GEN_TWO) ? clsr_pkg::MUL_TWO
                                                      : clsr_pkg::MUL_ONE;
    assign prod  = 47'(i_req.x) * 47'(mul_k);

    always_comb begin
        case (i_req.op)
            clsr_pkg::MM_FRAC: n_a_val = {i_req.x, {clsr_pkg::FRAC_W{1'b0}}};
            default:           n_a_val = PW'(prod);
        endcase
    end

    // stage b: fold bits above 2^31 back in as hi * (2^31 - modulus)
    assign fold_k  = (r_a_op == clsr_pkg::MM_GEN_TWO) ? clsr_pkg::FOLD_TWO
                                                      : clsr_pkg::FOLD_ONE;
    assign a_hi    = r_a_val[PW-1:clsr_pkg::GEN_W];
    assign n_b_sum = 33'(a_hi) * 33'(fold_k) + 33'(r_a_val[clsr_pkg::GEN_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_req.go;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_a_op  <= i_req.op;
            r_a_val <= n_a_val;
        end
        if (r_a_vld) begin
            r_b_op  <= r_a_op;
            r_b_sum <= n_b_sum;
            r_b_hi  <= a_hi;
        end
    end

    // final correction: folded sum stays below twice the modulus
    assign mod_k   = (r_b_op == clsr_pkg::MM_GEN_TWO) ? clsr_pkg::MOD_TWO
                                                      : clsr_pkg::MOD_ONE;
    assign ge_one  = (r_b_sum >= {1'b0, mod_k});
    assign ge_two  = (r_b_sum >= MOD_ONE_X2);
    assign sub_val = r_b_sum - {1'b0, mod_k};

    assign o_rsp.done = r_b_vld;
    assign o_rsp.op   = r_b_op;
    assign o_rsp.rem  = ge_one ? sub_val[clsr_pkg::GEN_W-1:0]
                               : r_b_sum[clsr_pkg::GEN_W-1:0];
    assign o_rsp.quo  = {1'b0, r_b_hi} + 25'(ge_one) + 25'(ge_two);

endmodule

// ----- tb/combined_lcg_shuffle_rng_tb.sv -----
// combined_lcg_shuffle_rng_tb: self-checking bench for the shuffled combined generator.
// Runs a directed table and then random draws, reseeds and seed writes against its own model.
// Depends on clsr_pkg, clsr_if and the combined_lcg_shuffle_rng RTL.

module combined_lcg_shuffle_rng_tb;

    localparam int          RANDOM_DRAWS   = 1000;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 200;
    localparam int          N_ROWS         = 20;
    localparam longint unsigned SLOT_DIV   =
        1 + (64'(clsr_pkg::MOD_ONE) - 2) / clsr_pkg::TABLE_SIZE;

    // seed corner values
    localparam logic [clsr_pkg::GEN_W-1:0] SEED_ZERO    = 31'd0;
    localparam logic [clsr_pkg::GEN_W-1:0] SEED_TOP     = 31'd2147483562;
    localparam logic [clsr_pkg::GEN_W-1:0] SEED_AT_MOD  = 31'd2147483563;
    localparam logic [clsr_pkg::GEN_W-1:0] SEED_PAST    = 31'd2147483564;
    localparam logic [clsr_pkg::GEN_W-1:0] SEED_ONES    = 31'h7FFFFFFF;
    localparam logic [clsr_pkg::GEN_W-1:0] SEED_KILL    = 31'd2147483399;

    typedef struct packed {
        logic [clsr_pkg::GEN_W-1:0]  sample;
        logic [clsr_pkg::FRAC_W-1:0] frac;
    } t_draw;

    typedef struct packed {
        logic                       load;
        logic [clsr_pkg::GEN_W-1:0] seed;
        logic                       restart;
        logic                       known;
        logic [clsr_pkg::GEN_W-1:0] sample;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    clsr_req_if req_if ();
    clsr_rsp_if rsp_if ();
    clsr_cfg_if cfg_if ();

    combined_lcg_shuffle_rng u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // model state of the generator
    logic [clsr_pkg::GEN_W-1:0] seed_reg;
    logic [clsr_pkg::GEN_W-1:0] gen_one;
    logic [clsr_pkg::GEN_W-1:0] gen_two;
    logic [clsr_pkg::GEN_W-1:0] prev_sample;
    logic [clsr_pkg::GEN_W-1:0] shuffle_tbl [clsr_pkg::TABLE_SIZE];

    t_draw pending_draws [$];

    int  n_errors;
    int  n_draws;
    int  n_reseeds;
    int  n_seed_writes;
    int  n_results;
    bit  req_burst;
    bit  rsp_burst;

    // draw straight out of reset: empty table, so the sample is the wrap minus generator two
    t_row directed_rows [N_ROWS] = '{
        '{1'b0, SEED_ZERO,     1'b0, 1'b1, 31'd1407495835},
        '{1'b0, SEED_ZERO,     1'b0, 1'b0, 31'd0},
        '{1'b0, SEED_ZERO,     1'b1, 1'b0, 31'd0},
        '{1'b0, SEED_ZERO,     1'b0, 1'b0, 31'd0},
        '{1'b1, SEED_ZERO,     1'b1, 1'b0, 31'd0},
        '{1'b0, SEED_ZERO,     1'b0, 1'b0, 31'd0},
        '{1'b1, SEED_TOP,      1'b1, 1'b0, 31'd0},
        '{1'b0, SEED_ZERO,     1'b0, 1'b0, 31'd0},
        '{1'b1, SEED_AT_MOD,   1'b1, 1'b0, 31'd0},
        '{1'b1, SEED_PAST,     1'b1, 1'b0, 31'd0},
        '{1'b1, SEED_ONES,     1'b1, 1'b0, 31'd0},
        '{1'b1, SEED_KILL,     1'b1, 1'b0, 31'd0},
        '{1'b0, SEED_ZERO,     1'b0, 1'b0, 31'd0},
        '{1'b0, SEED_ZERO,     1'b0, 1'b0, 31'd0},
        '{1'b0, SEED_ZERO,     1'b0, 1'b0, 31'd0},
        '{1'b1, 31'h2AAAAAAA,  1'b1, 1'b0, 31'd0},
        '{1'b1, 31'h55555555,  1'b1, 1'b0, 31'd0},
        '{1'b0, SEED_ZERO,     1'b1, 1'b0, 31'd0},
        '{1'b0, SEED_ZERO,     1'b1, 1'b0, 31'd0},
        '{1'b0, SEED_ZERO,     1'b0, 1'b0, 31'd0}
    };

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [clsr_pkg::GEN_W-1:0] lcg_one(
            input logic [clsr_pkg::GEN_W-1:0] x);
        return clsr_pkg::GEN_W'((64'(clsr_pkg::MUL_ONE) * 64'(x)) % 64'(clsr_pkg::MOD_ONE));
    endfunction

    function automatic logic [clsr_pkg::GEN_W-1:0] lcg_two(
            input logic [clsr_pkg::GEN_W-1:0] y);
        return clsr_pkg::GEN_W'((64'(clsr_pkg::MUL_TWO) * 64'(y)) % 64'(clsr_pkg::MOD_TWO));
    endfunction

    // advance the model by one request and return the sample it yields
    function automatic t_draw predict_draw(input logic restart);
        logic [clsr_pkg::GEN_W-1:0] x;
        longint unsigned            slot;
        longint                     diff;
        longint unsigned            q;
        t_draw                      d;
        if (restart) begin
            // reload and warm up generator one, filling the table from the top slot down
            x = seed_reg;
            if (64'(x) >= 64'(clsr_pkg::MOD_ONE))
                x = clsr_pkg::GEN_W'(64'(x) - 64'(clsr_pkg::MOD_ONE));
            if (x == '0)
                x = 31'd1;
            gen_two = x;
            for (int j = clsr_pkg::TABLE_SIZE + 7; j >= 0; j--) begin
                x = lcg_one(x);
                if (j < clsr_pkg::TABLE_SIZE)
                    shuffle_tbl[j] = x;
            end
            gen_one     = x;
            prev_sample = shuffle_tbl[0];
        end
        gen_one = lcg_one(gen_one);
        gen_two = lcg_two(gen_two);
        // slot picked from the previous sample, clamped into the table
        slot = 64'(prev_sample) / SLOT_DIV;
        if (slot >= clsr_pkg::TABLE_SIZE)
            slot = clsr_pkg::TABLE_SIZE - 1;
        diff = longint'(64'(shuffle_tbl[slot])) - longint'(64'(gen_two));
        shuffle_tbl[slot] = gen_one;
        if (diff < 1)
            diff = diff + longint'(64'(clsr_pkg::WRAP_ADD));
        prev_sample = clsr_pkg::GEN_W'(diff);
        // fraction of the modulus, held two steps under unity
        q = (64'(prev_sample) << clsr_pkg::FRAC_W) / 64'(clsr_pkg::MOD_ONE);
        if (q > 64'(clsr_pkg::FRAC_MAX))
            q = 64'(clsr_pkg::FRAC_MAX);
        d.sample = prev_sample;
        d.frac   = clsr_pkg::FRAC_W'(q);
        return d;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [clsr_pkg::GEN_W-1:0] pick_seed();
        case ($urandom_range(0, 9))
            0:       return SEED_ZERO;
            1:       return 31'd1;
            2:       return SEED_TOP;
            3:       return SEED_AT_MOD;
            4:       return SEED_ONES;
            5:       return SEED_KILL;
            default: return clsr_pkg::GEN_W'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        n_errors++;
        $display("mismatch on result %0d, %s: got %0d expected %0d",
                 n_results, what, got, want);
    endtask

    // one request beat, predicted at the edge it is accepted
    task automatic send_draw(input logic restart, input logic known,
                             input logic [clsr_pkg::GEN_W-1:0] typed_sample);
        int    gap;
        t_draw want;
        gap = req_burst ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid   <= 1'b1;
        req_if.restart <= restart;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        want = predict_draw(restart);
        if (known)
            want.sample = typed_sample;
        pending_draws.push_back(want);
        n_draws++;
        if (restart)
            n_reseeds++;
    endtask

    // hold off requests until every result is back
    task automatic drain_draws();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
    endtask

    // seed write, only with the block idle
    task automatic load_seed(input logic [clsr_pkg::GEN_W-1:0] value);
        drain_draws();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.seed  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        seed_reg = value;
        n_seed_writes++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // result receiver with random stalls
    initial begin
        int stall;
        stall = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0 && !rsp_burst) begin
                rsp_if.ready <= 1'b0;
                stall--;
            end else begin
                rsp_if.ready <= 1'b1;
                stall = rsp_burst ? 0 : pick_gap();
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_draw want;
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_draws.size() == 0) begin
                report_mismatch("unexpected beat, sample", rsp_if.sample, 0);
            end else begin
                want = pending_draws.pop_front();
                if (rsp_if.sample !== want.sample)
                    report_mismatch("sample", rsp_if.sample, want.sample);
                if (rsp_if.fraction_q24 !== want.frac)
                    report_mismatch("fraction_q24", rsp_if.fraction_q24, want.frac);
            end
            n_results++;
        end
    end

    // watchdog on cycles with no beat on any channel
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                    || (cfg_if.valid && cfg_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_draws.size());
        $display("FAILURE");
        $finish;
    end

    // stimulus
    initial begin
        int  sent;
        int  phase_len;
        bit  reseed_first;
        logic rs;

        n_errors      = 0;
        n_draws       = 0;
        n_reseeds     = 0;
        n_seed_writes = 0;
        n_results     = 0;
        req_burst     = 1'b0;
        rsp_burst     = 1'b0;
        req_if.valid   = 1'b0;
        req_if.restart = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.seed    = '0;

        // model reset state
        seed_reg    = clsr_pkg::SEED_RESET;
        gen_one     = clsr_pkg::ONE_RESET;
        gen_two     = clsr_pkg::TWO_RESET;
        prev_sample = '0;
        for (int i = 0; i < clsr_pkg::TABLE_SIZE; i++)
            shuffle_tbl[i] = '0;

        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            if (directed_rows[r].load)
                load_seed(directed_rows[r].seed);
            send_draw(directed_rows[r].restart, directed_rows[r].known,
                      directed_rows[r].sample);
        end

        // random phases, some opening with a seed write
        sent = 0;
        while (sent < RANDOM_DRAWS) begin
            req_burst    = ($urandom_range(0, 3) == 0);
            rsp_burst    = ($urandom_range(0, 3) == 0);
            reseed_first = 1'b0;
            if ($urandom_range(0, 2) == 0) begin
                load_seed(pick_seed());
                reseed_first = ($urandom_range(0, 9) != 0);
            end
            phase_len = $urandom_range(8, 60);
            for (int k = 0; k < phase_len; k++) begin
                rs = (k == 0 && reseed_first) ? 1'b1 : ($urandom_range(0, 11) == 0);
                send_draw(rs, 1'b0, '0);
                sent++;
            end
        end

        drain_draws();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d draws (%0d with reseed) and %0d seed writes",
                 n_draws, n_reseeds, n_seed_writes);
        $display("%0d result beats checked, %0d mismatches", n_results, n_errors);
        if (n_errors == 0 && pending_draws.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
